>>> hdl/point_in_polygon_assert.svh
// ----------------------------------------------------------------------------
// Point-in-polygon assertion macros
// Concurrent assertion helpers for the point-in-polygon block. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_ASSERT_SVH
`define POINT_IN_POLYGON_ASSERT_SVH

`ifndef SYNTHESIS
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PIP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PIP_ASSERT(lbl, prop, msg)
`define PIP_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Sizes, request codes, item types and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned DIFF_W       = COORD_BITS + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;

  localparam logic [CNT_W-1:0] SEG_COUNT_RESET = 7'd3;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_VERTEX  = 2'd0;
  localparam logic [1:0] REQ_SEGMENT = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [5:0]                   entry_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic [5:0]                   seg_first;
    logic [5:0]                   seg_second;
  } pip_in_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossings_left;
  } pip_out_t;

  typedef struct packed {
    logic             start;
    logic             vtx_we;
    logic             seg_we;
    logic             issue;
    logic [IDX_W-1:0] issue_idx;
    logic             finish;
  } pip_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } pip_sts_t;

endpackage

>>> hdl/pip_ctrl.sv
// ----------------------------------------------------------------------------
// Point-in-polygon controller
// Takes items, holds the segment count register and sequences the segment
// walk of a query through the datapath.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic                    cfg_we_i,
  input  logic [6:0]              cfg_wdata_i,
  input  pip_pkg::pip_sts_t       sts_i,
  output pip_pkg::pip_cmd_t       cmd_o
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] seg_cnt_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] walk_len;
  logic             accept;
  logic             last_seg;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Counts above the table size walk the whole table.
  assign walk_len = (seg_cnt_q > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : seg_cnt_q;
  assign last_seg = (CNT_W'(idx_q) == (walk_len - CNT_W'(1)));

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cmd_o           = '0;
    cmd_o.issue_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.vtx_we = (req_type_i == REQ_VERTEX);
          cmd_o.seg_we = (req_type_i == REQ_SEGMENT);
          if (req_type_i == REQ_QUERY) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            state_d     = (walk_len == '0) ? ST_DRAIN : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        if (last_seg) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      seg_cnt_q <= SEG_COUNT_RESET;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        seg_cnt_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> hdl/pip_dp.sv
// ----------------------------------------------------------------------------
// Point-in-polygon datapath
// Vertex and segment tables, the per-segment crossing pipeline, the crossing
// counter and the output register.
// ----------------------------------------------------------------------------
module pip_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pip_pkg::pip_in_t        in_item_i,
  input  pip_pkg::pip_cmd_t       cmd_i,
  output pip_pkg::pip_sts_t       sts_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pip_pkg::pip_out_t       out_item_o
);
  import pip_pkg::*;

  logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
  logic [VIDX_W-1:0]            ss_mem [MAX_SEGMENTS];
  logic [VIDX_W-1:0]            se_mem [MAX_SEGMENTS];

  logic [3:0]                   vld_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [VIDX_W-1:0]            seg_a_q, seg_b_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;

  logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                         swap;
  logic                         skip_d, skip_q, skip2_q;
  logic signed [DIFF_W-1:0]     dx_d, dyp_d, dxp_d, dy_d;
  logic signed [DIFF_W-1:0]     dx_q, dyp_q, dxp_q, dy_q;
  logic signed [PROD_W-1:0]     lprod_q, rprod_q;
  logic [CNT_W-1:0]             tally_q;

  logic                         out_valid_q;
  pip_out_t                     out_q;

  // Table writes and registered reads. The segment read feeds the vertex
  // reads in the next cycle, so each vertex table is read at two addresses.
  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_we) begin
      vx_mem[in_item_i.entry_index[VIDX_W-1:0]] <= in_item_i.coord_x;
      vy_mem[in_item_i.entry_index[VIDX_W-1:0]] <= in_item_i.coord_y;
    end
    if (cmd_i.seg_we) begin
      ss_mem[in_item_i.entry_index[IDX_W-1:0]] <= in_item_i.seg_first[VIDX_W-1:0];
      se_mem[in_item_i.entry_index[IDX_W-1:0]] <= in_item_i.seg_second[VIDX_W-1:0];
    end
    seg_a_q <= ss_mem[cmd_i.issue_idx];
    seg_b_q <= se_mem[cmd_i.issue_idx];
    x1_q    <= vx_mem[seg_a_q];
    y1_q    <= vy_mem[seg_a_q];
    x2_q    <= vx_mem[seg_b_q];
    y2_q    <= vy_mem[seg_b_q];
  end

  // Order the endpoints by y, test the span and form the four differences.
  always_comb begin
    swap   = (y1_q > y2_q);
    lo_x   = swap ? x2_q : x1_q;
    lo_y   = swap ? y2_q : y1_q;
    hi_x   = swap ? x1_q : x2_q;
    hi_y   = swap ? y1_q : y2_q;
    skip_d = (py_q > hi_y) || (py_q < lo_y) || (lo_y == hi_y);
    dx_d   = $signed({hi_x[COORD_BITS-1], hi_x}) - $signed({lo_x[COORD_BITS-1], lo_x});
    dyp_d  = $signed({py_q[COORD_BITS-1], py_q}) - $signed({lo_y[COORD_BITS-1], lo_y});
    dxp_d  = $signed({px_q[COORD_BITS-1], px_q}) - $signed({lo_x[COORD_BITS-1], lo_x});
    dy_d   = $signed({hi_y[COORD_BITS-1], hi_y}) - $signed({lo_y[COORD_BITS-1], lo_y});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_item_i.coord_x;
      py_q <= in_item_i.coord_y;
    end
    dx_q    <= dx_d;
    dyp_q   <= dyp_d;
    dxp_q   <= dxp_d;
    dy_q    <= dy_d;
    skip_q  <= skip_d;
    // The crossing lies strictly left of the point when dx*dyp < dxp*dy.
    lprod_q <= dx_q * dyp_q;
    rprod_q <= dxp_q * dy_q;
    skip2_q <= skip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[2:0], cmd_i.issue};
      if (cmd_i.start) begin
        tally_q <= '0;
      end else if (vld_q[3] && !skip2_q && (lprod_q < rprod_q)) begin
        tally_q <= tally_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.inside_res     <= tally_q[0];
      out_q.crossings_left <= tally_q;
    end
  end

  assign sts_o.pipe_busy = |vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule

>>> hdl/point_in_polygon.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test by crossing number
// Holds vertex and segment tables and counts, for each query point, the
// boundary segments crossed strictly left of the point.
// ----------------------------------------------------------------------------
//  channel | signals                              | carries
//  --------+--------------------------------------+---------------------------
//  in      | in_valid_i, in_stall_o, in_item_i    | vertex, segment or query
//  out     | out_valid_o, out_stall_i, out_item_o | crossing count, inside flag
//  cfg     | cfg_we_i, cfg_wdata_i                | segment_count
//
//  A query walking N segments (N = segment_count, at most 64) occupies the
//  block until its result is loaded: one segment enters the read, compare
//  and multiply pipeline per cycle, and the walk waits for that pipeline to
//  empty. A query with segment_count 0 walks nothing.
//  Reset clears control state and sets segment_count to 3; the tables are
//  undefined until written. A finished result waits in the output register
//  while further writes are taken; a query that ends while it is still held
//  waits for it to be taken.
// ----------------------------------------------------------------------------
`include "point_in_polygon_assert.svh"

module point_in_polygon (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pip_pkg::pip_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pip_pkg::pip_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i
);
  import pip_pkg::*;

  pip_cmd_t cmd;
  pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (in_item_i.req_type),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pip_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // A result is only loaded once every segment has left the pipeline.
  `PIP_ASSERT_NEVER(a_finish_drained, cmd.finish && sts.pipe_busy, "result loaded while pipeline busy")
  `PIP_ASSERT(a_out_from_finish, $rose(out_valid_o) |-> $past(cmd.finish), "result without finish")
  // The block only takes items with an empty pipeline.
  `PIP_ASSERT_NEVER(a_idle_empty, !in_stall_o && sts.pipe_busy, "item taken while walk in flight")
  `PIP_ASSERT(a_parity, out_valid_o |-> (out_item_o.inside_res == out_item_o.crossings_left[0]), "inside flag differs from parity")

endmodule
